// ===== sv/lld_pkg.sv =====
// Shared constants, types and helper functions for the lat/lon distance and bearing block.
package lld_pkg;

  localparam int DEF_CORDIC_STEPS    = 24;
  localparam int DEF_SCALE_FRAC_BITS = 20;

  // scale factor in mm per 1e-7 degree, Q.32, split for two narrow multiplies
  localparam logic [35:0] FACT_Q32 = 36'd47811079880;
  localparam logic [17:0] FACT_HI  = FACT_Q32[35:18];
  localparam logic [17:0] FACT_LO  = FACT_Q32[17:0];

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam logic signed [33:0] HALF_CIRCLE = 34'sd1800000000;
  localparam logic signed [33:0] FULL_CIRCLE = 34'sd3600000000;
  localparam logic [30:0]        QUARTER_LAT = 31'd900000000;
  localparam logic [34:0]        OFS_MAX     = 35'h7FFFFFFFF;

  // angle = (a * 2^32 + 1.8e9) / 3.6e9, i.e. (a * 2^22 + bias) / 3515625.
  // Estimated as (a * R + ANG_RECIP_BIAS) >> 32 with R = floor(2^54 / 3515625)
  // = 2^32 + ANG_RECIP_LO; the estimate is low by at most one.
  localparam logic [21:0] ANG_DIVISOR    = 22'd3515625;
  localparam logic [51:0] ANG_BIAS       = 52'd1757812;
  localparam logic [29:0] ANG_RECIP_LO   = 30'd829128280;
  localparam logic [31:0] ANG_RECIP_BIAS = 32'd2147483037;

  typedef struct packed {
    logic        dlat_neg;
    logic [31:0] dlat_mag;
    logic        dlng_neg;
    logic [31:0] dlng_mag;
  } lld_side_t;

  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // saturate a magnitude to OFS_MAX, then apply the sign
  function automatic logic [35:0] sat_ofs(input logic neg, input logic [37:0] mag);
    logic [34:0] m;
    m = (mag > {3'b000, OFS_MAX}) ? OFS_MAX : mag[34:0];
    return neg ? 36'(-{1'b0, m}) : {1'b0, m};
  endfunction

endpackage

// ===== sv/lld_cos_pipe.sv =====
// Pipelined cosine of mean latitude: reciprocal angle estimate, rotation CORDIC, clamp.
module lld_cos_pipe #(
  parameter int CORDIC_STEPS    = lld_pkg::DEF_CORDIC_STEPS,
  parameter int SCALE_FRAC_BITS = lld_pkg::DEF_SCALE_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [30:0]                in_mag,
  input  logic                       in_pole,
  input  lld_pkg::lld_side_t         in_side,
  output logic                       out_valid,
  output logic [SCALE_FRAC_BITS+1:0] out_cq,
  output lld_pkg::lld_side_t         out_side
);

  localparam int XW        = 36;
  localparam int ZW        = 34;
  localparam int CQW       = SCALE_FRAC_BITS + 2;
  localparam int FLOOR_Q   = ((1 << SCALE_FRAC_BITS) + 50) / 100;
  localparam logic signed [XW-1:0] CQ_HALF = XW'(1) << (31 - SCALE_FRAC_BITS);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 pole;
    lld_pkg::lld_side_t   side;
  } rot_t;

  // A1: low part of the reciprocal product
  logic               a1_vld_r;
  logic [30:0]        a1_mag_r;
  logic [59:0]        a1_prod_r;
  logic               a1_pole_r;
  lld_pkg::lld_side_t a1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a1_vld_r <= 1'b0;
    else        a1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    a1_mag_r  <= in_mag;
    a1_prod_r <= 60'(in_mag) * 60'(lld_pkg::ANG_RECIP_LO);
    a1_pole_r <= in_pole;
    a1_side_r <= in_side;
  end

  // A2: quotient estimate, low by at most one; pole inputs give junk that is never used
  logic [61:0]        est;
  logic [51:0]        num;
  logic               a2_vld_r;
  logic [29:0]        a2_q0_r;
  logic [51:0]        a2_num_r;
  logic               a2_pole_r;
  lld_pkg::lld_side_t a2_side_r;

  always_comb begin
    est = 62'({a1_mag_r, 32'd0}) + 62'(a1_prod_r) + 62'(lld_pkg::ANG_RECIP_BIAS);
    num = 52'({a1_mag_r, 22'd0}) + lld_pkg::ANG_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a2_vld_r <= 1'b0;
    else        a2_vld_r <= a1_vld_r;
  end

  always_ff @(posedge clk) begin
    a2_q0_r   <= est[61:32];
    a2_num_r  <= num;
    a2_pole_r <= a1_pole_r;
    a2_side_r <= a1_side_r;
  end

  // A3: estimate times divisor
  logic               a3_vld_r;
  logic [51:0]        a3_qd_r;
  logic [29:0]        a3_q0_r;
  logic [51:0]        a3_num_r;
  logic               a3_pole_r;
  lld_pkg::lld_side_t a3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a3_vld_r <= 1'b0;
    else        a3_vld_r <= a2_vld_r;
  end

  always_ff @(posedge clk) begin
    a3_qd_r   <= 52'(a2_q0_r) * 52'(lld_pkg::ANG_DIVISOR);
    a3_q0_r   <= a2_q0_r;
    a3_num_r  <= a2_num_r;
    a3_pole_r <= a2_pole_r;
    a3_side_r <= a2_side_r;
  end

  // A4: bump the estimate when one more divisor still fits
  logic [51:0]        qd_top;
  logic               q_up;
  logic [29:0]        ang_nxt;
  logic               a4_vld_r;
  logic [29:0]        a4_ang_r;
  logic               a4_pole_r;
  lld_pkg::lld_side_t a4_side_r;

  always_comb begin
    qd_top  = a3_qd_r + 52'(lld_pkg::ANG_DIVISOR);
    q_up    = (a3_num_r >= qd_top);
    ang_nxt = a3_q0_r + 30'(q_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a4_vld_r <= 1'b0;
    else        a4_vld_r <= a3_vld_r;
  end

  always_ff @(posedge clk) begin
    a4_ang_r  <= ang_nxt;
    a4_pole_r <= a3_pole_r;
    a4_side_r <= a3_side_r;
  end

  logic rot_vld_r [CORDIC_STEPS];
  rot_t rot_r     [CORDIC_STEPS];

  rot_t rot_init;

  always_comb begin
    rot_init.x    = XW'(lld_pkg::INV_GAIN);
    rot_init.y    = '0;
    rot_init.z    = ZW'(a4_ang_r);
    rot_init.pole = a4_pole_r;
    rot_init.side = a4_side_r;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    rot_t src;
    logic src_vld;
    rot_t rot_nxt;
    logic signed [XW-1:0] sx, sy, dx, dy;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign src     = rot_init;
      assign src_vld = a4_vld_r;
    end else begin : g_rest
      assign src     = rot_r[i-1];
      assign src_vld = rot_vld_r[i-1];
    end

    always_comb begin
      rot_nxt = src;
      sx  = src.x;
      sy  = src.y;
      dx  = sy >>> i;
      dy  = sx >>> i;
      ang = $signed({2'b00, lld_pkg::atan_at(5'(i))});
      if (!src.z[ZW-1]) begin
        rot_nxt.x = sx - dx;
        rot_nxt.y = sy + dy;
        rot_nxt.z = src.z - ang;
      end else begin
        rot_nxt.x = sx + dx;
        rot_nxt.y = sy - dy;
        rot_nxt.z = src.z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) rot_vld_r[i] <= 1'b0;
      else        rot_vld_r[i] <= src_vld;
    end

    always_ff @(posedge clk) begin
      rot_r[i] <= rot_nxt;
    end
  end

  logic signed [XW-1:0] cq_sum, cq_raw, fx;
  logic [CQW-1:0]       cq_nxt;
  logic                 out_valid_r;
  logic [CQW-1:0]       out_cq_r;
  lld_pkg::lld_side_t   out_side_r;

  always_comb begin
    fx     = rot_r[CORDIC_STEPS-1].x;
    cq_sum = fx + CQ_HALF;
    cq_raw = cq_sum >>> (32 - SCALE_FRAC_BITS);
    if (rot_r[CORDIC_STEPS-1].pole || (cq_raw < $signed(XW'(FLOOR_Q)))) begin
      cq_nxt = CQW'(FLOOR_Q);
    end else begin
      cq_nxt = cq_raw[CQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= rot_vld_r[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    out_cq_r   <= cq_nxt;
    out_side_r <= rot_r[CORDIC_STEPS-1].side;
  end

  assign out_valid = out_valid_r;
  assign out_cq    = out_cq_r;
  assign out_side  = out_side_r;

endmodule

// ===== sv/lld_vec_pipe.sv =====
// Pipelined vectoring CORDIC: range and compass bearing from north and east offsets.
module lld_vec_pipe #(
  parameter int CORDIC_STEPS = lld_pkg::DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [35:0] in_north,
  input  logic signed [35:0] in_east,
  output logic               out_valid,
  output logic [35:0]        out_north,
  output logic [35:0]        out_east,
  output logic [34:0]        out_range,
  output logic [15:0]        out_head
);

  localparam int VW = 55;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic [35:0]          north;
    logic [35:0]          east;
  } vec_t;

  typedef struct packed {
    logic [58:0] p_lo;
    logic [58:0] p_hi;
    logic [15:0] head;
    logic        zero;
    logic [35:0] north;
    logic [35:0] east;
  } mul_t;

  vec_t init_nxt, init_r;
  logic init_vld_r;
  logic signed [VW-1:0] xin, yin;

  always_comb begin
    xin = VW'($signed({in_north, 16'd0}));
    yin = VW'($signed({in_east, 16'd0}));
    init_nxt.zero  = (in_north == '0) && (in_east == '0);
    init_nxt.north = in_north;
    init_nxt.east  = in_east;
    if (in_north[35]) begin
      init_nxt.x = -xin;
      init_nxt.y = -yin;
      init_nxt.z = 32'h80000000;
    end else begin
      init_nxt.x = xin;
      init_nxt.y = yin;
      init_nxt.z = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) init_vld_r <= 1'b0;
    else        init_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    init_r <= init_nxt;
  end

  logic vec_vld_r [CORDIC_STEPS];
  vec_t vec_r     [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    vec_t src;
    logic src_vld;
    vec_t vec_nxt;
    logic signed [VW-1:0] sx, sy, dx, dy;
    logic [31:0] ang;

    if (i == 0) begin : g_first
      assign src     = init_r;
      assign src_vld = init_vld_r;
    end else begin : g_rest
      assign src     = vec_r[i-1];
      assign src_vld = vec_vld_r[i-1];
    end

    always_comb begin
      vec_nxt = src;
      sx  = src.x;
      sy  = src.y;
      dx  = sy >>> i;
      dy  = sx >>> i;
      ang = lld_pkg::atan_at(5'(i));
      if (!sy[VW-1] && (sy != '0)) begin
        vec_nxt.x = sx + dx;
        vec_nxt.y = sy - dy;
        vec_nxt.z = src.z + ang;
      end else begin
        vec_nxt.x = sx - dx;
        vec_nxt.y = sy + dy;
        vec_nxt.z = src.z - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vec_vld_r[i] <= 1'b0;
      else        vec_vld_r[i] <= src_vld;
    end

    always_ff @(posedge clk) begin
      vec_r[i] <= vec_nxt;
    end
  end

  // gain correction, split into two 27x32 products
  vec_t        fin;
  logic [53:0] xc;
  logic [31:0] hsum;
  mul_t        mul_nxt, mul_r;
  logic        mul_vld_r;

  always_comb begin
    fin  = vec_r[CORDIC_STEPS-1];
    xc   = fin.x[VW-1] ? 54'd0 : fin.x[53:0];
    hsum = fin.z + 32'h8000;
    mul_nxt.p_lo  = 59'(xc[26:0]) * 59'(lld_pkg::INV_GAIN);
    mul_nxt.p_hi  = 59'(xc[53:27]) * 59'(lld_pkg::INV_GAIN);
    mul_nxt.head  = hsum[31:16];
    mul_nxt.zero  = fin.zero;
    mul_nxt.north = fin.north;
    mul_nxt.east  = fin.east;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mul_vld_r <= 1'b0;
    else        mul_vld_r <= vec_vld_r[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
  end

  logic [85:0] full;
  logic [37:0] range_u;
  logic [34:0] range_nxt;
  logic [15:0] head_nxt;
  logic        out_valid_r;
  logic [35:0] out_north_r, out_east_r;
  logic [34:0] out_range_r;
  logic [15:0] out_head_r;

  always_comb begin
    full    = {mul_r.p_hi, 27'd0} + 86'(mul_r.p_lo) + (86'(1) << 47);
    range_u = full[85:48];
    if (mul_r.zero) begin
      range_nxt = '0;
      head_nxt  = '0;
    end else begin
      range_nxt = (range_u > 38'(lld_pkg::OFS_MAX)) ? lld_pkg::OFS_MAX : range_u[34:0];
      head_nxt  = mul_r.head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= mul_vld_r;
  end

  always_ff @(posedge clk) begin
    out_north_r <= mul_r.north;
    out_east_r  <= mul_r.east;
    out_range_r <= range_nxt;
    out_head_r  <= head_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_north = out_north_r;
  assign out_east  = out_east_r;
  assign out_range = out_range_r;
  assign out_head  = out_head_r;

endmodule

// ===== sv/latlon_distance_and_bearing.sv =====
// Top level: flat-earth north/east offset, range and bearing between two positions.
//
// Usage: drive the four position fields with start high; a transaction is taken at
// every rising edge where start is high and busy is low. busy is low whenever the
// block is out of reset, so one transaction may be started in every cycle.
// Each result appears on the out_ ports for exactly one cycle with out_valid high.
// Throughput is one transaction per cycle. The path from start to out_valid runs
// through the front stage, the four-stage reciprocal estimate that turns mean
// latitude into an angle, the rotation CORDIC pipeline for the cosine, the split
// multiplies and the vectoring CORDIC pipeline for range and bearing, both unrolled.
// Results leave in the order the transactions came in. The receiver cannot stall,
// so nothing is held back. Synchronous reset clears every valid bit in the
// pipeline; transactions in flight are dropped and busy is high during reset.
module latlon_distance_and_bearing #(
  parameter int CORDIC_STEPS    = lld_pkg::DEF_CORDIC_STEPS,
  parameter int SCALE_FRAC_BITS = lld_pkg::DEF_SCALE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_lat_from,
  input  logic signed [31:0] in_lng_from,
  input  logic signed [30:0] in_lat_to,
  input  logic signed [31:0] in_lng_to,
  output logic               out_valid,
  output logic signed [35:0] out_north_mm,
  output logic signed [35:0] out_east_mm,
  output logic [34:0]        out_range_mm,
  output logic [15:0]        out_heading_turns
);

  localparam int CQW     = SCALE_FRAC_BITS + 2;
  localparam int EW      = SCALE_FRAC_BITS + 54;
  localparam int FLOOR_Q = ((1 << SCALE_FRAC_BITS) + 50) / 100;
  localparam int LAT     = 2 * CORDIC_STEPS + 13;
  localparam logic [EW-1:0] E_HALF = EW'(1) << (15 + SCALE_FRAC_BITS);

  assign busy = !rst_n;

  // front stage: differences, longitude wrap, mean latitude magnitude
  logic signed [31:0] lat_sum, mean, dlat;
  logic signed [33:0] dlng_raw, dlng_w;
  logic [30:0]        mean_mag;
  logic               s1_vld_r;
  logic [30:0]        s1_mag_r;
  logic               s1_pole_r;
  lld_pkg::lld_side_t s1_side_r, s1_side_nxt;

  always_comb begin
    lat_sum  = 32'(in_lat_from) + 32'(in_lat_to);
    mean     = $signed(lat_sum + 32'(lat_sum[31])) >>> 1;
    mean_mag = mean[31] ? 31'(-mean) : mean[30:0];
    dlat     = 32'(in_lat_to) - 32'(in_lat_from);
    dlng_raw = 34'(in_lng_to) - 34'(in_lng_from);
    if (dlng_raw > lld_pkg::HALF_CIRCLE)       dlng_w = dlng_raw - lld_pkg::FULL_CIRCLE;
    else if (dlng_raw < -lld_pkg::HALF_CIRCLE) dlng_w = dlng_raw + lld_pkg::FULL_CIRCLE;
    else                                       dlng_w = dlng_raw;
    s1_side_nxt.dlat_neg = dlat[31];
    s1_side_nxt.dlat_mag = dlat[31] ? 32'(-dlat) : 32'(dlat);
    s1_side_nxt.dlng_neg = dlng_w[33];
    s1_side_nxt.dlng_mag = dlng_w[33] ? 32'(-dlng_w) : dlng_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_mag_r  <= mean_mag;
    s1_pole_r <= (mean_mag >= lld_pkg::QUARTER_LAT);
    s1_side_r <= s1_side_nxt;
  end

  logic               cos_valid;
  logic [CQW-1:0]     cos_cq;
  lld_pkg::lld_side_t cos_side;

  lld_cos_pipe #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_vld_r),
    .in_mag   (s1_mag_r),
    .in_pole  (s1_pole_r),
    .in_side  (s1_side_r),
    .out_valid(cos_valid),
    .out_cq   (cos_cq),
    .out_side (cos_side)
  );

  // E1: partial products of the scale factor
  logic           e1_vld_r;
  logic [49:0]    e1_nh_r, e1_nl_r, e1_th_r, e1_tl_r;
  logic           e1_nneg_r, e1_eneg_r;
  logic [CQW-1:0] e1_cq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e1_vld_r <= 1'b0;
    else        e1_vld_r <= cos_valid;
  end

  always_ff @(posedge clk) begin
    e1_nh_r   <= 50'(cos_side.dlat_mag) * 50'(lld_pkg::FACT_HI);
    e1_nl_r   <= 50'(cos_side.dlat_mag) * 50'(lld_pkg::FACT_LO);
    e1_th_r   <= 50'(cos_side.dlng_mag) * 50'(lld_pkg::FACT_HI);
    e1_tl_r   <= 50'(cos_side.dlng_mag) * 50'(lld_pkg::FACT_LO);
    e1_nneg_r <= cos_side.dlat_neg;
    e1_eneg_r <= cos_side.dlng_neg;
    e1_cq_r   <= cos_cq;
  end

  // E2: north done, scaled east magnitude t
  logic [67:0]    nfull, tfull;
  logic [35:0]    north_nxt;
  logic [51:0]    t_nxt;
  logic           e2_vld_r;
  logic [35:0]    e2_north_r;
  logic [51:0]    e2_t_r;
  logic           e2_eneg_r;
  logic [CQW-1:0] e2_cq_r;

  always_comb begin
    nfull     = {e1_nh_r, 18'd0} + 68'(e1_nl_r) + (68'(1) << 31);
    tfull     = {e1_th_r, 18'd0} + 68'(e1_tl_r) + (68'(1) << 15);
    north_nxt = lld_pkg::sat_ofs(e1_nneg_r, {2'b00, nfull[67:32]});
    t_nxt     = tfull[67:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e2_vld_r <= 1'b0;
    else        e2_vld_r <= e1_vld_r;
  end

  always_ff @(posedge clk) begin
    e2_north_r <= north_nxt;
    e2_t_r     <= t_nxt;
    e2_eneg_r  <= e1_eneg_r;
    e2_cq_r    <= e1_cq_r;
  end

  // E3: t times cosine, two partial products
  logic              e3_vld_r;
  logic [CQW+25:0]   e3_pl_r, e3_ph_r;
  logic [35:0]       e3_north_r;
  logic              e3_eneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e3_vld_r <= 1'b0;
    else        e3_vld_r <= e2_vld_r;
  end

  always_ff @(posedge clk) begin
    e3_pl_r    <= (CQW+26)'(e2_t_r[25:0]) * (CQW+26)'(e2_cq_r);
    e3_ph_r    <= (CQW+26)'(e2_t_r[51:26]) * (CQW+26)'(e2_cq_r);
    e3_north_r <= e2_north_r;
    e3_eneg_r  <= e2_eneg_r;
  end

  // E4: east rounded and saturated
  logic [EW-1:0] efull;
  logic [35:0]   east_nxt;
  logic          e4_vld_r;
  logic [35:0]   e4_north_r, e4_east_r;

  always_comb begin
    efull    = {e3_ph_r, 26'd0} + EW'(e3_pl_r) + E_HALF;
    east_nxt = lld_pkg::sat_ofs(e3_eneg_r, efull[EW-1:16+SCALE_FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e4_vld_r <= 1'b0;
    else        e4_vld_r <= e3_vld_r;
  end

  always_ff @(posedge clk) begin
    e4_north_r <= e3_north_r;
    e4_east_r  <= east_nxt;
  end

  logic [35:0] vec_north, vec_east;

  lld_vec_pipe #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (e4_vld_r),
    .in_north ($signed(e4_north_r)),
    .in_east  ($signed(e4_east_r)),
    .out_valid(out_valid),
    .out_north(vec_north),
    .out_east (vec_east),
    .out_range(out_range_mm),
    .out_head (out_heading_turns)
  );

  assign out_north_mm = $signed(vec_north);
  assign out_east_mm  = $signed(vec_east);

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_cos_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cos_valid |-> (cos_cq >= CQW'(FLOOR_Q)))
    else $error("cosine below floor");

  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_north_mm == '0) && (out_east_mm == '0))
      |-> ((out_range_mm == '0) && (out_heading_turns == '0)))
    else $error("coincident points give nonzero range or heading");

endmodule
